// ----- rtl/core/sparse_topk_softmax_assert.svh -----
// Assertion macros for the sparse top-k softmax block.
// Included by the port checker; needs clock and reset in the including scope.
`ifndef SPARSE_TOPK_SOFTMAX_ASSERT_SVH
`define SPARSE_TOPK_SOFTMAX_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define STSM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define STSM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/stsm_pkg.sv -----
// Shared types, constants and the exp factor table of the sparse top-k softmax.
// No dependencies; imported by every module of the block.
package stsm_pkg;

   localparam int IDX_W    = 6;
   localparam int CNT_W    = 7;
   localparam int LOGIT_W  = 32;
   localparam int INV_W    = 24;
   localparam int MARGIN_W = 24;
   localparam int THR_W    = 16;
   localparam int PROB_W   = 17;
   localparam int MASS_W   = 24;
   localparam int ACC_W    = 31;
   localparam int TAB_W    = 30;
   localparam int X_W      = 22;
   localparam int XB_W     = 5;
   localparam int PADDR_W  = 4;
   localparam int PDATA_W  = 32;

   localparam logic [PROB_W-1:0]  ONE_Q16     = 17'h10000;
   localparam logic [32:0]        EXP_LIMIT   = 33'd3932160;
   localparam logic [INV_W-1:0]   INV_DEFAULT = 24'h010000;

   typedef enum logic [1:0] {
      REG_INV_TEMP = 2'd0,
      REG_KEEP     = 2'd1,
      REG_MARGIN   = 2'd2,
      REG_SLEEP    = 2'd3
   } reg_idx_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_READ,
      OP_SEL_BEGIN,
      OP_SEL_CMP,
      OP_SEL_COMMIT,
      OP_EXP_START,
      OP_EXP_WRITE,
      OP_NRM_START,
      OP_NRM_WRITE,
      OP_RN_START,
      OP_RN_WRITE,
      OP_ONEHOT,
      OP_OUT_LOAD
   } op_type;

   typedef struct packed {
      logic             accept;
      op_type           op;
      logic [IDX_W-1:0] addr;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] keep_eff;
      logic             exp_busy;
      logic             div_busy;
      logic             mass_zero;
      logic             kept_zero;
      logic             sum2_one;
      logic             rsp_free;
   } status_type;

   typedef struct packed {
      logic [INV_W-1:0]    inv;
      logic [CNT_W-1:0]    keep;
      logic [MARGIN_W-1:0] margin;
      logic [THR_W-1:0]    thr;
   } cfg_type;

   // round(2^30 * exp(-2^(b-16)))
   function automatic logic [TAB_W-1:0] exp_tab(input logic [XB_W-1:0] b);
      logic [TAB_W-1:0] v;
      case (b)
         5'd0:    v = 30'd1073725440;
         5'd1:    v = 30'd1073709056;
         5'd2:    v = 30'd1073676290;
         5'd3:    v = 30'd1073610760;
         5'd4:    v = 30'd1073479712;
         5'd5:    v = 30'd1073217664;
         5'd6:    v = 30'd1072693760;
         5'd7:    v = 30'd1071646719;
         5'd8:    v = 30'd1069555701;
         5'd9:    v = 30'd1065385899;
         5'd10:   v = 30'd1057095000;
         5'd11:   v = 30'd1040706261;
         5'd12:   v = 30'd1008687096;
         5'd13:   v = 30'd947573834;
         5'd14:   v = 30'd836230973;
         5'd15:   v = 30'd651257337;
         5'd16:   v = 30'd395007542;
         5'd17:   v = 30'd145315154;
         5'd18:   v = 30'd19666268;
         5'd19:   v = 30'd360200;
         5'd20:   v = 30'd121;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/stsm_if.sv -----
// Valid/ready channel interfaces for the logit input and the probability output.
// Depend on stsm_pkg for field widths.
interface stsm_req_if;
   import stsm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [LOGIT_W-1:0] logit;
   logic                      last;
   modport source (output valid, output logit, output last, input ready);
   modport sink   (input valid, input logit, input last, output ready);
endinterface

interface stsm_rsp_if;
   import stsm_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  position;
   logic [PROB_W-1:0] probability;
   logic              final_res;
   modport source (output valid, output position, output probability, output final_res,
                   input ready);
   modport sink   (input valid, input position, input probability, input final_res,
                   output ready);
endinterface

// ----- rtl/core/sparse_topk_softmax.sv -----
// Sparse top-k softmax over a vector of signed Q16.16 logits.
// req_bus carries one logit per transaction; last closes the vector. Items
//   past MAX_ITEMS are dropped, but a dropped last still closes the vector.
// rsp_bus returns one Q1.16 probability per stored element in index order,
//   final_res set on the last one.
// Configuration goes through the APB-style port: inverse temperature at 0x0,
//   keep count at 0x4, peak margin at 0x8, sleep threshold at 0xC. Write only
//   while no vector is in flight.
// Loading accepts one logit per cycle while no vector is in flight. After last,
//   with n elements and k kept: k top-k passes over the score memory, each
//   reading all n elements; then one bit-serial exp per element, a divider pass
//   over the elements to normalize, an optional divider pass to renormalize, and
//   the emission of each element. For small k the 22-step exp loop and the
//   17-step divider dominate, for large k the selection passes do; one vector is
//   in flight at a time.
// Reset is synchronous: it returns to loading, restores register defaults and
//   clears the element count and keep flags; no clearing pass is needed.
// A stalled receiver holds the result register; emission waits on it and
//   nothing is lost.
// Depends on stsm_pkg, stsm_if, stsm_csr, stsm_ctrl and stsm_datapath.
module sparse_topk_softmax #(
   parameter int MAX_ITEMS      = 64,
   parameter int EXP_TABLE_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   stsm_req_if.sink                      req_bus,
   stsm_rsp_if.source                    rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [stsm_pkg::PADDR_W-1:0]  paddr,
   input  logic [stsm_pkg::PDATA_W-1:0]  pwdata,
   output logic [stsm_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);
   import stsm_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // register file; the zero-scale fixup happens here
   stsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: owns the handshake on the input side and the element index
   stsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic; drives the result register
   stsm_datapath #(
      .MAX_ITEMS      (MAX_ITEMS),
      .EXP_TABLE_BITS (EXP_TABLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_logit       (req_bus.logit),
      .rsp_ready       (rsp_bus.ready),
      .status          (status),
      .rsp_valid       (rsp_bus.valid),
      .rsp_position    (rsp_bus.position),
      .rsp_probability (rsp_bus.probability),
      .rsp_final       (rsp_bus.final_res)
   );

endmodule

// ----- rtl/core/stsm_csr.sv -----
// APB-style configuration registers of the sparse top-k softmax.
// Depends on stsm_pkg.
module stsm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [stsm_pkg::PADDR_W-1:0]  paddr,
   input  logic [stsm_pkg::PDATA_W-1:0]  pwdata,
   output logic [stsm_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output stsm_pkg::cfg_type             cfg
);
   import stsm_pkg::*;

   logic [INV_W-1:0]    inv_ff;
   logic [CNT_W-1:0]    keep_ff;
   logic [MARGIN_W-1:0] margin_ff;
   logic [THR_W-1:0]    thr_ff;
   reg_idx_type         sel;
   logic                wr_en;

   assign sel    = reg_idx_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff    <= INV_DEFAULT;
         keep_ff   <= CNT_W'(1);
         margin_ff <= MARGIN_W'(262144);
         thr_ff    <= THR_W'(7);
      end else if (wr_en) begin
         case (sel)
            REG_INV_TEMP: inv_ff    <= pwdata[INV_W-1:0];
            REG_KEEP:     keep_ff   <= pwdata[CNT_W-1:0];
            REG_MARGIN:   margin_ff <= pwdata[MARGIN_W-1:0];
            REG_SLEEP:    thr_ff    <= pwdata[THR_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_INV_TEMP: prdata = PDATA_W'(inv_ff);
         REG_KEEP:     prdata = PDATA_W'(keep_ff);
         REG_MARGIN:   prdata = PDATA_W'(margin_ff);
         REG_SLEEP:    prdata = PDATA_W'(thr_ff);
         default:      prdata = '0;
      endcase
   end

   // zero scale means unity
   assign cfg.inv    = (inv_ff == '0) ? INV_DEFAULT : inv_ff;
   assign cfg.keep   = keep_ff;
   assign cfg.margin = margin_ff;
   assign cfg.thr    = thr_ff;

endmodule

// ----- rtl/core/stsm_datapath.sv -----
// Datapath: logit scaling, score and weight memories, top-k scan, exp unit,
// serial divider and the result register. Depends on stsm_pkg.
module stsm_datapath #(
   parameter int MAX_ITEMS      = 64,
   parameter int EXP_TABLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  stsm_pkg::cmd_type                 cmd,
   input  stsm_pkg::cfg_type                 cfg,
   input  logic signed [stsm_pkg::LOGIT_W-1:0] req_logit,
   input  logic                              rsp_ready,
   output stsm_pkg::status_type              status,
   output logic                              rsp_valid,
   output logic [stsm_pkg::IDX_W-1:0]        rsp_position,
   output logic [stsm_pkg::PROB_W-1:0]       rsp_probability,
   output logic                              rsp_final
);
   import stsm_pkg::*;

   localparam int IW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int DROP = 16 - EXP_TABLE_BITS;
   localparam int PW   = LOGIT_W + INV_W + 1;
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ITEMS);
   localparam logic [X_W-1:0]   X_MASK   = ~X_W'((1 << DROP) - 1);

   logic signed [LOGIT_W-1:0] scaled_mem [MAX_ITEMS];
   logic [PROB_W-1:0]         weight_mem [MAX_ITEMS];

   logic [MAX_ITEMS-1:0]      keep_ff;
   logic                      st_valid_ff;
   logic signed [LOGIT_W-1:0] st_logit_ff;
   logic signed [PW-1:0]      st_prod_ff;
   logic [CNT_W-1:0]          count_ff;
   logic signed [LOGIT_W-1:0] peak_ff;
   logic [IW-1:0]             raw_idx_ff;
   logic signed [LOGIT_W-1:0] raw_val_ff;
   logic [CNT_W-1:0]          keep_eff_ff;
   logic signed [LOGIT_W-1:0] rd_scaled_ff;
   logic [PROB_W-1:0]         rd_weight_ff;
   logic [IW-1:0]             addr_d_ff;
   logic                      best_valid_ff;
   logic signed [LOGIT_W-1:0] best_val_ff;
   logic [IW-1:0]             best_idx_ff;
   logic                      exp_busy_ff;
   logic                      exp_live_ff;
   logic [X_W-1:0]            x_ff;
   logic [XB_W-1:0]           bit_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic                      div_busy_ff;
   logic [XB_W-1:0]           div_cnt_ff;
   logic [MASS_W-1:0]         rem_ff;
   logic [PROB_W-1:0]         dvd_ff;
   logic [PROB_W-1:0]         quo_ff;
   logic [MASS_W-1:0]         dsr_ff;
   logic [MASS_W-1:0]         mass_ff;
   logic [MASS_W-1:0]         sum2_ff;
   logic [CNT_W-1:0]          kept_ff;
   logic                      onehot_ff;
   logic                      rsp_valid_ff;
   logic [IDX_W-1:0]          rsp_pos_ff;
   logic [PROB_W-1:0]         rsp_prob_ff;
   logic                      rsp_final_ff;

   logic [IW-1:0]             addr;
   logic signed [PW-1:0]      prod;
   logic signed [PW-17:0]     quot;
   logic signed [LOGIT_W-1:0] sat;
   logic                      fits;
   logic signed [33:0]        floor_v;
   logic [32:0]               gap;
   logic [60:0]               mprod;
   logic [ACC_W-1:0]          acc_next;
   logic [PROB_W-1:0]         w_new;
   logic [MASS_W-1:0]         dsr_sel;
   logic [33:0]               dividend;
   logic [MASS_W:0]           rem2;
   logic                      qbit;
   logic [PROB_W-1:0]         p_slept;
   logic [CNT_W-1:0]          keep_clamp;
   logic                      is_final;

   assign addr = cmd.addr[IW-1:0];

   // scale: floor(logit * inv / 2^16), saturated to 32 bits
   assign prod = PW'(req_logit) * $signed({1'b0, cfg.inv});
   assign quot = st_prod_ff[PW-1:16];
   assign fits = (quot[PW-17:LOGIT_W-1] == '0) || (quot[PW-17:LOGIT_W-1] == '1);
   always_comb begin
      if (fits)            sat = quot[LOGIT_W-1:0];
      else if (quot[PW-17]) sat = {1'b1, {(LOGIT_W-1){1'b0}}};
      else                 sat = {1'b0, {(LOGIT_W-1){1'b1}}};
   end

   assign floor_v = 34'(peak_ff) - $signed({10'd0, cfg.margin});
   assign gap     = 33'($signed(33'(peak_ff)) - $signed(33'(rd_scaled_ff)));

   assign mprod    = 61'(acc_ff) * 61'(exp_tab(bit_ff));
   assign acc_next = ACC_W'((mprod + 61'(1 << 29)) >> 30);
   assign w_new    = exp_live_ff ? PROB_W'((32'(acc_ff) + 32'd8192) >> 14) : '0;

   assign dsr_sel  = (cmd.op == OP_NRM_START) ? mass_ff : sum2_ff;
   assign dividend = {1'b0, rd_weight_ff, 16'd0} + 34'(dsr_sel >> 1);
   assign rem2     = {rem_ff, dvd_ff[PROB_W-1]};
   assign qbit     = (rem2 >= {1'b0, dsr_ff});

   assign p_slept = ((quo_ff != '0) && (quo_ff < {1'b0, cfg.thr})) ? '0 : quo_ff;

   always_comb begin
      if (cfg.keep == '0)          keep_clamp = CNT_W'(1);
      else if (cfg.keep > count_ff) keep_clamp = count_ff;
      else                         keep_clamp = cfg.keep;
   end

   assign is_final = (CNT_W'(addr_d_ff) + CNT_W'(1)) == count_ff;

   // memories
   always_ff @(posedge clock) begin
      if (st_valid_ff && count_ff < MAX_CNT) begin
         scaled_mem[count_ff[IW-1:0]] <= sat;
      end
      if (cmd.op == OP_EXP_WRITE) begin
         weight_mem[addr_d_ff] <= w_new;
      end else if (cmd.op == OP_NRM_WRITE) begin
         weight_mem[addr_d_ff] <= p_slept;
      end else if (cmd.op == OP_RN_WRITE) begin
         weight_mem[addr_d_ff] <= quo_ff;
      end
      if (cmd.op == OP_READ) begin
         rd_scaled_ff <= scaled_mem[addr];
         rd_weight_ff <= weight_mem[addr];
         addr_d_ff    <= addr;
      end
   end

   // load stage, peak and raw argmax
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
         count_ff    <= '0;
         peak_ff     <= '0;
         raw_idx_ff  <= '0;
      end else begin
         st_valid_ff <= cmd.accept;
         if (cmd.accept) begin
            st_logit_ff <= req_logit;
            st_prod_ff  <= prod;
         end
         if (st_valid_ff && count_ff < MAX_CNT) begin
            if (count_ff == '0 || sat > peak_ff) peak_ff <= sat;
            if (count_ff == '0 || st_logit_ff > raw_val_ff) begin
               raw_idx_ff <= count_ff[IW-1:0];
               raw_val_ff <= st_logit_ff;
            end
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.op == OP_OUT_LOAD && is_final) begin
            count_ff <= '0;
         end
      end
   end

   // selection, exp unit, divider, sums
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff       <= '0;
         best_valid_ff <= 1'b0;
         exp_busy_ff   <= 1'b0;
         exp_live_ff   <= 1'b0;
         div_busy_ff   <= 1'b0;
         mass_ff       <= '0;
         sum2_ff       <= '0;
         kept_ff       <= '0;
         onehot_ff     <= 1'b0;
         keep_eff_ff   <= CNT_W'(1);
      end else begin
         case (cmd.op)
            OP_CLEAR: begin
               keep_ff     <= '0;
               keep_eff_ff <= keep_clamp;
               mass_ff     <= '0;
               sum2_ff     <= '0;
               kept_ff     <= '0;
               onehot_ff   <= 1'b0;
            end
            OP_SEL_BEGIN: best_valid_ff <= 1'b0;
            OP_SEL_CMP: begin
               // strict compare in index order keeps the lower index on ties
               if (!keep_ff[addr_d_ff] && (!best_valid_ff || rd_scaled_ff > best_val_ff)) begin
                  best_valid_ff <= 1'b1;
                  best_val_ff   <= rd_scaled_ff;
                  best_idx_ff   <= addr_d_ff;
               end
            end
            OP_SEL_COMMIT: begin
               if (best_valid_ff && 34'(best_val_ff) >= floor_v) keep_ff[best_idx_ff] <= 1'b1;
            end
            OP_EXP_START: begin
               if (keep_ff[addr_d_ff] && gap <= EXP_LIMIT) begin
                  exp_live_ff <= 1'b1;
                  exp_busy_ff <= 1'b1;
               end else begin
                  exp_live_ff <= 1'b0;
                  keep_ff[addr_d_ff] <= 1'b0;
               end
               x_ff   <= gap[X_W-1:0] & X_MASK;
               bit_ff <= '0;
               acc_ff <= ACC_W'(1 << 30);
            end
            OP_EXP_WRITE: mass_ff <= mass_ff + MASS_W'(w_new);
            OP_NRM_START, OP_RN_START: begin
               div_busy_ff <= 1'b1;
               div_cnt_ff  <= '0;
               rem_ff      <= MASS_W'(dividend[33:PROB_W]);
               dvd_ff      <= dividend[PROB_W-1:0];
               dsr_ff      <= dsr_sel;
            end
            OP_NRM_WRITE: begin
               if (p_slept != '0) begin
                  kept_ff <= kept_ff + CNT_W'(1);
                  sum2_ff <= sum2_ff + MASS_W'(p_slept);
               end
            end
            OP_ONEHOT: onehot_ff <= 1'b1;
            default: ;
         endcase

         if (exp_busy_ff) begin
            if (x_ff[bit_ff]) acc_ff <= acc_next;
            bit_ff <= bit_ff + XB_W'(1);
            if (bit_ff == XB_W'(X_W - 1)) exp_busy_ff <= 1'b0;
         end

         if (div_busy_ff) begin
            rem_ff     <= qbit ? MASS_W'(rem2 - {1'b0, dsr_ff}) : rem2[MASS_W-1:0];
            dvd_ff     <= {dvd_ff[PROB_W-2:0], 1'b0};
            quo_ff     <= {quo_ff[PROB_W-2:0], qbit};
            div_cnt_ff <= div_cnt_ff + XB_W'(1);
            if (div_cnt_ff == XB_W'(PROB_W - 1)) div_busy_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_OUT_LOAD) begin
         rsp_pos_ff   <= IDX_W'(addr_d_ff);
         rsp_final_ff <= is_final;
         if (onehot_ff) rsp_prob_ff <= (addr_d_ff == raw_idx_ff) ? ONE_Q16 : '0;
         else           rsp_prob_ff <= rd_weight_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_final       = rsp_final_ff;

   assign status.count     = count_ff;
   assign status.keep_eff  = keep_eff_ff;
   assign status.exp_busy  = exp_busy_ff;
   assign status.div_busy  = div_busy_ff;
   assign status.mass_zero = (mass_ff == '0);
   assign status.kept_zero = (kept_ff == '0);
   assign status.sum2_one  = (sum2_ff == MASS_W'(ONE_Q16));
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

endmodule

// ----- rtl/core/stsm_ctrl.sv -----
// Sequencer of the sparse top-k softmax: load, top-k passes, exp, normalize,
// sleep renormalize and emit. Depends on stsm_pkg.
module stsm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  stsm_pkg::status_type status,
   output stsm_pkg::cmd_type    cmd
);
   import stsm_pkg::*;

   typedef enum logic [4:0] {
      ST_LOAD, ST_FLUSH, ST_CLEAR,
      ST_SEL_BEGIN, ST_SEL_RD, ST_SEL_CMP, ST_SEL_END,
      ST_EXP_RD, ST_EXP_GO, ST_EXP_WAIT, ST_MASS_CHK,
      ST_NRM_RD, ST_NRM_GO, ST_NRM_WAIT, ST_KEPT_CHK,
      ST_RN_RD, ST_RN_GO, ST_RN_WAIT,
      ST_OUT_RD, ST_OUT_SEND
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pass_ff, pass_in;
   logic             idx_last;

   assign idx_last = (idx_ff + CNT_W'(1)) == status.count;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      pass_in    = pass_ff;
      req_ready  = (state_ff == ST_LOAD);
      cmd.accept = req_ready & req_valid;
      cmd.op     = OP_NONE;
      cmd.addr   = idx_ff[IDX_W-1:0];
      case (state_ff)
         ST_LOAD: begin
            if (cmd.accept && req_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: state_in = ST_CLEAR;
         ST_CLEAR: begin
            cmd.op   = OP_CLEAR;
            pass_in  = '0;
            state_in = ST_SEL_BEGIN;
         end
         ST_SEL_BEGIN: begin
            cmd.op   = OP_SEL_BEGIN;
            idx_in   = '0;
            state_in = ST_SEL_RD;
         end
         ST_SEL_RD: begin
            cmd.op   = OP_READ;
            state_in = ST_SEL_CMP;
         end
         ST_SEL_CMP: begin
            cmd.op = OP_SEL_CMP;
            if (idx_last) begin
               state_in = ST_SEL_END;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_SEL_RD;
            end
         end
         ST_SEL_END: begin
            cmd.op = OP_SEL_COMMIT;
            if (pass_ff + CNT_W'(1) >= status.keep_eff) begin
               idx_in   = '0;
               state_in = ST_EXP_RD;
            end else begin
               pass_in  = pass_ff + CNT_W'(1);
               state_in = ST_SEL_BEGIN;
            end
         end
         ST_EXP_RD: begin
            cmd.op   = OP_READ;
            state_in = ST_EXP_GO;
         end
         ST_EXP_GO: begin
            cmd.op   = OP_EXP_START;
            state_in = ST_EXP_WAIT;
         end
         ST_EXP_WAIT: begin
            if (!status.exp_busy) begin
               cmd.op = OP_EXP_WRITE;
               if (idx_last) begin
                  idx_in   = '0;
                  state_in = ST_MASS_CHK;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = ST_EXP_RD;
               end
            end
         end
         ST_MASS_CHK: begin
            if (status.mass_zero) begin
               cmd.op   = OP_ONEHOT;
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_NRM_RD;
            end
         end
         ST_NRM_RD: begin
            cmd.op   = OP_READ;
            state_in = ST_NRM_GO;
         end
         ST_NRM_GO: begin
            cmd.op   = OP_NRM_START;
            state_in = ST_NRM_WAIT;
         end
         ST_NRM_WAIT: begin
            if (!status.div_busy) begin
               cmd.op = OP_NRM_WRITE;
               if (idx_last) begin
                  idx_in   = '0;
                  state_in = ST_KEPT_CHK;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = ST_NRM_RD;
               end
            end
         end
         ST_KEPT_CHK: begin
            if (status.kept_zero) begin
               cmd.op   = OP_ONEHOT;
               state_in = ST_OUT_RD;
            end else if (status.sum2_one) begin
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_RN_RD;
            end
         end
         ST_RN_RD: begin
            cmd.op   = OP_READ;
            state_in = ST_RN_GO;
         end
         ST_RN_GO: begin
            cmd.op   = OP_RN_START;
            state_in = ST_RN_WAIT;
         end
         ST_RN_WAIT: begin
            if (!status.div_busy) begin
               cmd.op = OP_RN_WRITE;
               if (idx_last) begin
                  idx_in   = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = ST_RN_RD;
               end
            end
         end
         ST_OUT_RD: begin
            cmd.op   = OP_READ;
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (status.rsp_free) begin
               cmd.op = OP_OUT_LOAD;
               if (idx_last) begin
                  idx_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         idx_ff   <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

// ----- rtl/core/stsm_checker.sv -----
// Port-level checks of the sparse top-k softmax, bound to the top level.
// Depends on stsm_pkg and sparse_topk_softmax_assert.svh.
`include "sparse_topk_softmax_assert.svh"

module stsm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [stsm_pkg::IDX_W-1:0]    rsp_position,
   input logic [stsm_pkg::PROB_W-1:0]   rsp_probability,
   input logic                          rsp_final_res
);
   import stsm_pkg::*;

   // a closed vector stops intake until its results are worked out
   `STSM_ASSERT_NEXT(a_close_stops_intake, req_valid && req_ready && req_last, !req_ready,
      "input taken right after the closing transaction")

   `STSM_ASSERT_NOW(a_prob_in_range, rsp_valid, rsp_probability <= ONE_Q16,
      "probability above one")

   `STSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_position) && $stable(rsp_probability) && $stable(rsp_final_res),
      "stalled result changed")

endmodule

bind sparse_topk_softmax stsm_checker u_stsm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_last        (req_bus.last),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_position    (rsp_bus.position),
   .rsp_probability (rsp_bus.probability),
   .rsp_final_res   (rsp_bus.final_res)
);

// ----- test/tb_sparse_topk_softmax.sv -----
// Self-checking testbench for sparse_topk_softmax: random logit vectors, random
// handshake stalls and APB register settings, checked against an internal predictor.
// Depends on stsm_pkg, stsm_if and the sparse_topk_softmax RTL.
module tb_sparse_topk_softmax;
   import stsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VEC_MAX   = 64;
   localparam int TAB_BITS  = 10;
   localparam longint X_CAP = 64'd3932160;    // 60.0 in Q16.16

   // round(2^30 * exp(-2^(b-16))) for b = 0..21
   localparam longint unsigned EXP_FACTOR [22] = '{
      1073725440, 1073709056, 1073676290, 1073610760, 1073479712,
      1073217664, 1072693760, 1071646719, 1069555701, 1065385899,
      1057095000, 1040706261, 1008687096, 947573834, 836230973,
      651257337, 395007542, 145315154, 19666268, 360200, 121, 0};

   typedef struct {
      logic signed [31:0] logit;
      bit                 last;
   } logit_item_t;

   typedef struct {
      logic [IDX_W-1:0]  position;
      logic [PROB_W-1:0] probability;
      logic              final_res;
   } prob_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   stsm_req_if req ();
   stsm_rsp_if rsp ();

   sparse_topk_softmax dut (
      .clock(clock), .reset(reset), .req_bus(req), .rsp_bus(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   // Register mirror
   logic [23:0] m_inv    = 24'd65536;
   logic [6:0]  m_keep   = 7'd1;
   logic [23:0] m_margin = 24'd262144;
   logic [15:0] m_sleep  = 16'd7;

   // Predictor state
   logic signed [31:0] scaled_mem [VEC_MAX];
   logic signed [31:0] raw_mem [VEC_MAX];
   bit                 kept [VEC_MAX];
   longint unsigned    weight [VEC_MAX];
   int                 elem_cnt = 0;
   logic signed [31:0] peak = 0;
   int                 raw_best = 0;

   logit_item_t logit_q[$];
   prob_item_t  prob_q[$];
   int  mismatches = 0;
   bit  quiet = 0;      // no stalls in the closing stretch

   function automatic logic signed [31:0] scale(logic signed [31:0] v, logic [23:0] inv);
      longint p, q;
      p = longint'(v) * longint'({1'b0, inv});
      if (p >= 0) q = p >>> 16;
      else q = -((-p + 65535) >>> 16);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   function automatic longint unsigned exp_weight(longint unsigned x);
      longint unsigned acc;
      acc = 64'd1 << 30;
      x = x & ~((64'd1 << (16 - TAB_BITS)) - 1);
      for (int b = 0; b < 22; b++)
         if (x[b]) acc = (acc * EXP_FACTOR[b] + (64'd1 << 29)) >> 30;
      return (acc + 8192) >> 14;
   endfunction

   function automatic longint unsigned ratio_q16(longint unsigned w, longint unsigned sum);
      if (sum == 0) return 0;
      return (w * 65536 + sum / 2) / sum;
   endfunction

   // Fill weight[] for a closed vector of n elements.
   function automatic void solve_vector(int n);
      int k, support;
      longint unsigned mass, sum2, p;
      int survivors;
      longint floor_v, z;
      k = (m_keep == 0) ? 1 : int'(m_keep);
      if (k > n) k = n;
      support = 0;
      floor_v = longint'(peak) - longint'({1'b0, m_margin});
      for (int i = 0; i < n; i++) begin
         int rank;
         rank = 0;
         kept[i] = 0;
         for (int j = 0; j < n; j++)
            if (scaled_mem[j] > scaled_mem[i] || (scaled_mem[j] == scaled_mem[i] && j < i))
               rank++;
         if (rank < k && longint'(scaled_mem[i]) >= floor_v) begin
            kept[i] = 1;
            support++;
         end
      end
      if (support == 0) begin
         int best;
         best = 0;
         for (int i = 1; i < n; i++) if (scaled_mem[i] > scaled_mem[best]) best = i;
         kept[best] = 1;
      end
      mass = 0;
      for (int i = 0; i < n; i++) begin
         z = longint'(scaled_mem[i]) - longint'(peak);
         weight[i] = 0;
         if (kept[i]) begin
            if (z < -X_CAP) kept[i] = 0;
            else begin
               weight[i] = exp_weight(longint'(-z));
               mass += weight[i];
            end
         end
      end
      mass = mass & 64'hFFFFFF;
      survivors = 0;
      sum2 = 0;
      if (mass != 0)
         for (int i = 0; i < n; i++) begin
            p = kept[i] ? ratio_q16(weight[i], mass) : 0;
            if (p > 0 && p < m_sleep) p = 0;
            weight[i] = p;
            if (p > 0) begin
               survivors++;
               sum2 += p;
            end
         end
      if (mass == 0 || survivors == 0) begin
         // Nothing left: one-hot on the first raw maximum
         for (int i = 0; i < n; i++) weight[i] = (i == raw_best) ? 65536 : 0;
      end else if (sum2 != 65536) begin
         for (int i = 0; i < n; i++)
            if (weight[i] > 0) weight[i] = ratio_q16(weight[i], sum2);
      end
   endfunction

   // Update the predictor with one accepted logit transaction.
   function automatic void absorb_logit(logit_item_t it);
      logic [23:0] inv;
      logic signed [31:0] s;
      prob_item_t r;
      inv = (m_inv == 0) ? 24'd65536 : m_inv;
      if (elem_cnt < VEC_MAX) begin
         s = scale(it.logit, inv);
         raw_mem[elem_cnt] = it.logit;
         scaled_mem[elem_cnt] = s;
         if (elem_cnt == 0 || s > peak) peak = s;
         if (elem_cnt == 0 || it.logit > raw_mem[raw_best]) raw_best = elem_cnt;
         elem_cnt++;
      end
      if (!it.last) return;
      solve_vector(elem_cnt);
      for (int i = 0; i < elem_cnt; i++) begin
         r.position = i[IDX_W-1:0];
         r.probability = weight[i][PROB_W-1:0];
         r.final_res = (i + 1 == elem_cnt);
         prob_q.push_back(r);
      end
      elem_cnt = 0;
   endfunction

   // Request driver: feed logit_q, with random idle bursts.
   int req_idle = 0;
   initial begin
      req.valid = 1'b0;
      req.logit = '0;
      req.last = 1'b0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      logit_item_t it;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            it.logit = req.logit;
            it.last = req.last;
            absorb_logit(it);
         end
         if (!req.valid || req.ready) begin
            if (!quiet && req_idle == 0 && $urandom_range(0, 7) == 0)
               req_idle = $urandom_range(1, 9);
            if (req_idle > 0) begin
               req_idle--;
               req.valid <= 1'b0;
            end else if (logit_q.size() > 0) begin
               it = logit_q.pop_front();
               req.valid <= 1'b1;
               req.logit <= it.logit;
               req.last <= it.last;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: random backpressure, compare each transaction in order.
   int rsp_idle = 0;
   always @(posedge clock) begin
      prob_item_t want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (prob_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: pos=%0d prob=%0d final=%0b",
                           rsp.position, rsp.probability, rsp.final_res);
            end else begin
               want = prob_q.pop_front();
               if (rsp.position !== want.position || rsp.probability !== want.probability ||
                   rsp.final_res !== want.final_res) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected pos=%0d prob=%0d final=%0b, ",
                               "got pos=%0d prob=%0d final=%0b"},
                              want.position, want.probability, want.final_res,
                              rsp.position, rsp.probability, rsp.final_res);
               end
            end
         end
         if (!quiet && rsp_idle == 0 && $urandom_range(0, 7) == 0)
            rsp_idle = $urandom_range(1, 9);
         if (rsp_idle > 0) begin
            rsp_idle--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // APB write: setup then access; mirror updates at the access edge.
   task automatic csr_write(reg_idx_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_W'(4 * int'(idx));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_INV_TEMP: m_inv = value[23:0];
         REG_KEEP:     m_keep = value[6:0];
         REG_MARGIN:   m_margin = value[23:0];
         REG_SLEEP:    m_sleep = value[15:0];
         default:      ;
      endcase
   endtask

   task automatic set_all(logic [31:0] inv, logic [31:0] keep, logic [31:0] margin,
                          logic [31:0] sleep);
      csr_write(REG_INV_TEMP, inv);
      csr_write(REG_KEEP, keep);
      csr_write(REG_MARGIN, margin);
      csr_write(REG_SLEEP, sleep);
   endtask

   task automatic push_logit(logic signed [31:0] v, bit last);
      logit_item_t it;
      it.logit = v;
      it.last = last;
      logit_q.push_back(it);
   endtask

   // Hold until every queued transaction is accepted and every result is back.
   task automatic drain();
      while (logit_q.size() != 0 || req.valid || prob_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_logit(logic signed [31:0] prev);
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2:    return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
         3:    return prev;                                     // tie
         4:    return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $signed($urandom_range(0, 4 << 16)) - (2 << 16);
      endcase
   endfunction

   task automatic push_random_vector(int n);
      logic signed [31:0] v;
      v = 0;
      for (int i = 0; i < n; i++) begin
         v = pick_logit(v);
         push_logit(v, i == n - 1);
      end
   endtask

   initial begin
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults, extremes, ties, single element
      push_logit(32'sh7FFFFFFF, 0);
      push_logit(32'sh80000000, 1);
      push_logit(32'sh00010000, 1);
      push_logit(32'sh00020000, 0);
      push_logit(32'sh00020000, 0);
      push_logit(32'sh00020000, 1);
      drain();

      // Zero temperature, zero keep count, zero margin, zero sleep floor
      set_all(0, 0, 0, 0);
      push_logit(32'sh00030000, 0);
      push_logit(32'sh00030000, 0);
      push_logit(-32'sh00010000, 1);
      drain();

      // Saturating scale, oversized keep count, wide margin, deep exp underflow
      set_all(24'hFFFFFF, 127, 24'hFFFFFF, 1);
      push_logit(32'sh40000000, 0);
      push_logit(-32'sh40000000, 0);
      push_logit(32'sh00000001, 0);
      push_logit(32'sh00000000, 1);
      drain();

      // Everything sleeps: one-hot at the first raw maximum
      set_all(24'h010000, 2, 24'h040000, 16'hFFFF);
      push_logit(32'sh00050000, 0);
      push_logit(32'sh00050000, 1);
      drain();

      // Overflow: items past the store are dropped, last still closes
      set_all(24'h008000, 3, 24'h100000, 100);
      push_random_vector(66);
      drain();

      // Random phases
      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 9) quiet = 1;
         case (ph % 3)
            0: set_all($urandom_range(1, 24'hFFFFFF), $urandom_range(0, 127),
                       $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 16'hFFFF));
            1: set_all($urandom_range(1 << 12, 1 << 18), $urandom_range(1, 8),
                       $urandom_range(0, 16 << 16), $urandom_range(0, 2000));
            default: set_all($urandom_range(0, 1) ? 24'd1 : 24'hFFFFFF,
                             $urandom_range(0, 1) ? 7'd1 : 7'd64,
                             $urandom_range(0, 1) ? 24'd0 : 24'hFFFFFF,
                             $urandom_range(0, 1) ? 16'd0 : 16'hFFFF);
         endcase
         for (int v = 0; v < 2; v++) begin
            n = ($urandom_range(0, 29) == 0) ? 64 : $urandom_range(1, 4);
            push_random_vector(n);
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0 && prob_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #60ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
